// ===== hw/rtl/radix_integer_to_ascii_top_macros.svh =====
// ----------------------------------------------------------------------------
// radix integer to ascii assertion macros
// shared assertion forms for the block's checkers
// ----------------------------------------------------------------------------
`ifndef RADIX_INTEGER_TO_ASCII_TOP_MACROS_SVH
`define RADIX_INTEGER_TO_ASCII_TOP_MACROS_SVH

// same-cycle implication
`define RITA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RITA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rita_pkg.sv =====
// ----------------------------------------------------------------------------
// rita_pkg
// types, constants and the digit-to-character map of the radix converter
// ----------------------------------------------------------------------------
package rita_pkg;

  localparam int VALUE_W   = 31;
  localparam int RADIX_W   = 6;
  localparam int CHAR_W    = 8;
  localparam int DIGIT_W   = 6;

  localparam int VALUE_BITS_DEF  = 31;
  localparam int DIGIT_DEPTH_DEF = 32;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_BIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

  localparam logic [CHAR_W-1:0]  CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0]  CH_X      = 8'h78;
  localparam logic [CHAR_W-1:0]  CH_B      = 8'h62;
  localparam logic [CHAR_W-1:0]  DIGIT_GAP = 8'd7;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 6'd9;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
  } rita_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } rita_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rita_div_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = CH_ZERO + {2'b00, d};
    if (d > DIGIT_MAX) begin
      c = c + DIGIT_GAP;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/rita_div.sv =====
// ----------------------------------------------------------------------------
// rita_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rita_div #(
  parameter int VALUE_BITS = rita_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [VALUE_BITS-1:0]         dividend,
  input  logic [rita_pkg::RADIX_W-1:0]  divisor,
  output rita_pkg::rita_div_sts_t       sts,
  output logic [VALUE_BITS-1:0]         quot,
  output logic [rita_pkg::RADIX_W-1:0]  rem
);

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0]        quot_r, quot_nxt;
  logic [rita_pkg::RADIX_W-1:0] rem_r, rem_nxt;
  logic [rita_pkg::RADIX_W-1:0] divisor_r;
  logic [CNT_W-1:0]             cnt_r;
  logic                         busy_r, done_r;
  logic [rita_pkg::RADIX_W:0]   trial;
  logic                         fits;

  always_comb begin
    trial    = {rem_r, quot_r[VALUE_BITS-1]};
    fits     = trial >= {1'b0, divisor_r};
    rem_nxt  = fits ? rita_pkg::RADIX_W'(trial - {1'b0, divisor_r})
                    : trial[rita_pkg::RADIX_W-1:0];
    quot_nxt = {quot_r[VALUE_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(VALUE_BITS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r    <= dividend;
      rem_r     <= '0;
      divisor_r <= divisor;
    end else if (busy_r) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = quot_r;
  assign rem      = rem_r;

endmodule

// ===== hw/rtl/rita_seq.sv =====
// ----------------------------------------------------------------------------
// rita_seq
// conversion sequencer: drives the divider, keeps the digits, emits the text
// ----------------------------------------------------------------------------
module rita_seq #(
  parameter int VALUE_BITS  = rita_pkg::VALUE_BITS_DEF,
  parameter int DIGIT_DEPTH = rita_pkg::DIGIT_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  rita_pkg::rita_in_t            in_data,
  output logic                          out_valid,
  output rita_pkg::rita_out_t           out_data,
  output logic                          div_start,
  output logic [VALUE_BITS-1:0]         div_dividend,
  output logic [rita_pkg::RADIX_W-1:0]  div_divisor,
  input  rita_pkg::rita_div_sts_t       div_sts,
  input  logic [VALUE_BITS-1:0]         div_quot,
  input  logic [rita_pkg::RADIX_W-1:0]  div_rem
);

  localparam int AW    = $clog2(DIGIT_DEPTH);
  localparam int CW    = $clog2(DIGIT_DEPTH + 1);
  localparam int EXT_W = (VALUE_BITS > rita_pkg::VALUE_W) ? VALUE_BITS : rita_pkg::VALUE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVIDE,
    S_PREFIX0,
    S_PREFIX1,
    S_READ,
    S_EMIT
  } state_t;

  state_t                       state_r;
  logic [rita_pkg::RADIX_W-1:0] radix_r;
  logic [VALUE_BITS-1:0]        remaining_r;
  logic [CW-1:0]                count_r;
  logic                         div_go_r;
  logic                         out_valid_r;
  rita_pkg::rita_out_t          out_data_r;

  logic [rita_pkg::DIGIT_W-1:0] mem [DIGIT_DEPTH];
  logic [rita_pkg::DIGIT_W-1:0] rd_data_r;
  logic [CW-1:0]                count_m1;
  logic [AW-1:0]                rd_addr;
  logic [AW-1:0]                wr_addr;
  logic [rita_pkg::DIGIT_W-1:0] wr_data;
  logic                         wr_en;

  logic [EXT_W-1:0]             value_ext;
  logic [VALUE_BITS-1:0]        value_m;
  logic                         accept;
  logic                         has_prefix;
  logic                         room;

  always_comb begin
    value_ext  = EXT_W'(in_data.value);
    value_m    = value_ext[VALUE_BITS-1:0];
    accept     = start && (state_r == S_IDLE);
    has_prefix = (radix_r == rita_pkg::RADIX_HEX) || (radix_r == rita_pkg::RADIX_BIN);
    room       = count_r < CW'(DIGIT_DEPTH);
    count_m1   = count_r - 1'b1;
    rd_addr    = count_m1[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = count_r[AW-1:0];
    wr_data    = div_rem;
    if (accept && (value_m == '0)) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = '0;
    end else if ((state_r == S_DIVIDE) && div_sts.done && room) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      remaining_r <= '0;
      radix_r     <= rita_pkg::RADIX_MIN;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            radix_r     <= (in_data.radix < rita_pkg::RADIX_MIN) ? rita_pkg::RADIX_MIN
                                                                 : in_data.radix;
            remaining_r <= value_m;
            if (value_m == '0) begin
              count_r <= CW'(1);
              state_r <= S_PREFIX0;
            end else begin
              count_r  <= '0;
              div_go_r <= 1'b1;
              state_r  <= S_DIVIDE;
            end
          end
        end
        S_DIVIDE: begin
          if (div_sts.done) begin
            if (room) begin
              count_r <= count_r + 1'b1;
            end
            remaining_r <= div_quot;
            if (div_quot != '0) begin
              div_go_r <= 1'b1;
            end else begin
              state_r <= S_PREFIX0;
            end
          end
        end
        S_PREFIX0: begin
          if (has_prefix) begin
            out_valid_r          <= 1'b1;
            out_data_r.char_code <= rita_pkg::CH_ZERO;
            out_data_r.last      <= 1'b0;
            state_r              <= S_PREFIX1;
          end else begin
            state_r <= S_READ;
          end
        end
        S_PREFIX1: begin
          out_valid_r          <= 1'b1;
          out_data_r.char_code <= (radix_r == rita_pkg::RADIX_HEX) ? rita_pkg::CH_X
                                                                   : rita_pkg::CH_B;
          out_data_r.last      <= 1'b0;
          state_r              <= S_READ;
        end
        S_READ: begin
          count_r <= count_r - 1'b1;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          out_valid_r          <= 1'b1;
          out_data_r.char_code <= rita_pkg::digit_char(rd_data_r);
          out_data_r.last      <= (count_r == '0);
          state_r              <= (count_r == '0) ? S_IDLE : S_READ;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign div_start    = div_go_r && !div_sts.busy;
  assign div_dividend = remaining_r;
  assign div_divisor  = radix_r;

endmodule

// ===== hw/rtl/radix_integer_to_ascii_top.sv =====
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_top
// converts a non-negative integer to ascii text in radix 2 to 36
// ----------------------------------------------------------------------------
//  channel  ports                      transfer
//  input    start, busy, in_data       start high while busy low
//  result   out_valid, out_data        every cycle with out_valid high
//
//  per digit: a division in the shared divider (none for zero), then the S_READ and S_EMIT steps
//  plus the S_PREFIX0 step, and S_PREFIX1 as well when "0x" or "0b" is sent
//  the longest item at the defaults is radix 2 with 31 digits
//  synchronous reset leaves the block idle, no memory clearing
//  busy drops as the last character goes out; the receiver cannot stall
// ----------------------------------------------------------------------------
module radix_integer_to_ascii_top #(
  parameter int VALUE_BITS  = rita_pkg::VALUE_BITS_DEF,
  parameter int DIGIT_DEPTH = rita_pkg::DIGIT_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rita_pkg::rita_in_t  in_data,
  output logic                out_valid,
  output rita_pkg::rita_out_t out_data
);

  logic                         div_start;
  logic [VALUE_BITS-1:0]        div_dividend;
  logic [rita_pkg::RADIX_W-1:0] div_divisor;
  rita_pkg::rita_div_sts_t      div_sts;
  logic [VALUE_BITS-1:0]        div_quot;
  logic [rita_pkg::RADIX_W-1:0] div_rem;

  rita_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  rita_seq #(
    .VALUE_BITS  (VALUE_BITS),
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_sts      (div_sts),
    .div_quot     (div_quot),
    .div_rem      (div_rem)
  );

endmodule

// ===== hw/rtl/rita_checker.sv =====
// ----------------------------------------------------------------------------
// rita_checker
// port-level checks on the converter's command and result channels
// ----------------------------------------------------------------------------
`include "radix_integer_to_ascii_top_macros.svh"

module rita_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input rita_pkg::rita_out_t out_data
);

  logic in_xfer;

  assign in_xfer = start && !busy;

  `RITA_ASSERT_NXT(a_busy_after_xfer, in_xfer, busy, "busy not raised after input transfer")
  `RITA_ASSERT_NXT(a_no_out_after_xfer, in_xfer, !out_valid, "result right after input transfer")
  `RITA_ASSERT_IMP(a_busy_mid_string, out_valid && !out_data.last, busy, "idle mid string")
  `RITA_ASSERT_NXT(a_gap_after_last, out_valid && out_data.last, !out_valid, "result after last")

endmodule

bind radix_integer_to_ascii_top rita_checker u_rita_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
